>>> rtl/twom_pkg.sv
package twom_pkg;

   // Register indexes on the write port
   typedef enum logic [2:0] {
      CSR_TRIM_A      = 3'd0,
      CSR_TRIM_D      = 3'd1,
      CSR_CEILING     = 3'd2,
      CSR_FLOOR_SIDE  = 3'd3,
      CSR_FLOOR_REAR  = 3'd4
   } csr_index_type;

   localparam int unsigned PERCENT_FULL = 100;
   // floor(x/100) == (x*RECIP_100) >> RECIP_SHIFT for every x below 2^18
   localparam int unsigned RECIP_100   = 335545;
   localparam int unsigned RECIP_SHIFT = 25;
   localparam int unsigned DIV_STAGES  = 4;
   localparam int unsigned DIV_STEPS   = 3;

   // Stage 1: forward magnitude times trim
   typedef struct packed {
      logic               fneg;
      logic [17:0]        pa;
      logic [17:0]        pd;
      logic signed [10:0] turn;
      logic signed [10:0] lat;
   } s1_type;

   // Stage 2: trimmed forward magnitudes
   typedef struct packed {
      logic               fneg;
      logic [11:0]        qa;
      logic [11:0]        qd;
      logic signed [10:0] turn;
      logic signed [10:0] lat;
   } s2_type;

   // Stage 3: mixed wheels, order a, b, d
   typedef struct packed {
      logic [2:0][13:0] wheel;
   } s3_type;

   // Stage 4: magnitudes, signs and the largest magnitude
   typedef struct packed {
      logic [2:0][12:0] mag;
      logic [2:0]       neg;
      logic [12:0]      high;
      logic             scaled;
   } s4_type;

   // Divider stages: partial remainder, unconsumed numerator bits, quotient
   typedef struct packed {
      logic [2:0][12:0] rem;
      logic [2:0][11:0] low;
      logic [2:0][11:0] quo;
      logic [2:0][12:0] mag;
      logic [2:0]       neg;
      logic [12:0]      high;
      logic             scaled;
   } div_type;

   // One restoring step: returns {quotient bit, next remainder}
   function automatic logic [13:0] div_step(input logic [12:0] rem,
                                            input logic        nbit,
                                            input logic [12:0] high);
      logic [13:0] t;
      t = {rem, nbit};
      if (t >= {1'b0, high}) begin
         div_step = {1'b1, 13'(t - {1'b0, high})};
      end else begin
         div_step = {1'b0, t[12:0]};
      end
   endfunction

endpackage

>>> rtl/three_wheel_omni_mixer.sv
// Three-wheel omni base mixer.
// req_ channel carries one body command per transaction (forward, turn,
// lateral, 11-bit signed each); rsp_ channel returns one transaction per
// command with the three wheel drives and the scaled/dropped flags.
// Forward is trimmed per side wheel, the wheels are mixed, scaled down to
// the ceiling when the largest magnitude exceeds it, then wheels below
// their start floor are zeroed.
// Throughput: one transaction per cycle while the receiver keeps rsp_tready
// high; the ten-stage pipeline is led by two multiply stages, then a
// four-stage restoring divider (3 bits per stage) and a final output stage.
// csr_ writes take effect at the clock edge with csr_we high; write only
// while no transaction is in flight.
// Reset empties the pipeline and loads the register defaults (trims 100,
// ceiling 100, floors 0).
// When rsp_tready is low the output holds; each stage stalls only when it
// and everything after it is full, so bubbles are squeezed out and nothing
// is lost or repeated.
module three_wheel_omni_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // forward_cmd, turn_cmd, lateral_cmd, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // wheel_a, wheel_b, wheel_d, was_scaled,
                                    // was_dropped, zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata
);
   import twom_pkg::*;

   localparam int NS = 10;

   logic [7:0]  trim_a_ff, trim_d_ff;
   logic [11:0] ceil_ff, floor_side_ff, floor_rear_ff;
   logic [7:0]  trim_a, trim_d;
   logic [11:0] ceil_eff;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] ready;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   div_type d_ff [DIV_STAGES+1];
   div_type d_in [DIV_STAGES+1];
   logic [47:0] out_ff, out_in;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         trim_a_ff     <= 8'd100;
         trim_d_ff     <= 8'd100;
         ceil_ff       <= 12'd100;
         floor_side_ff <= 12'd0;
         floor_rear_ff <= 12'd0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TRIM_A:     trim_a_ff     <= csr_wdata[7:0];
            CSR_TRIM_D:     trim_d_ff     <= csr_wdata[7:0];
            CSR_CEILING:    ceil_ff       <= csr_wdata;
            CSR_FLOOR_SIDE: floor_side_ff <= csr_wdata;
            CSR_FLOOR_REAR: floor_rear_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Substitute full scale for zero trims and ceiling
   assign trim_a   = (trim_a_ff == '0) ? 8'(PERCENT_FULL) : trim_a_ff;
   assign trim_d   = (trim_d_ff == '0) ? 8'(PERCENT_FULL) : trim_d_ff;
   assign ceil_eff = (ceil_ff == '0) ? 12'(PERCENT_FULL) : ceil_ff;

   // Stall chain: a stage advances when empty or when its successor moves
   always_comb begin
      ready[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS-2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_tready = ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NS; k++) begin
            if (ready[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Stage 1: trim multiply on forward magnitude
   always_comb begin
      logic signed [10:0] fwd;
      logic [10:0]        afwd;
      fwd        = $signed(req_tdata[10:0]);
      afwd       = fwd[10] ? 11'(-fwd) : 11'(fwd);
      s1_in.fneg = fwd[10];
      s1_in.pa   = 18'(afwd) * 18'(trim_a);
      s1_in.pd   = 18'(afwd) * 18'(trim_d);
      s1_in.turn = $signed(req_tdata[21:11]);
      s1_in.lat  = $signed(req_tdata[32:22]);
   end

   // Stage 2: divide by 100 through the reciprocal
   always_comb begin
      logic [36:0] ma, md;
      ma         = 37'(s1_ff.pa) * 37'(RECIP_100);
      md         = 37'(s1_ff.pd) * 37'(RECIP_100);
      s2_in.fneg = s1_ff.fneg;
      s2_in.qa   = ma[RECIP_SHIFT +: 12];
      s2_in.qd   = md[RECIP_SHIFT +: 12];
      s2_in.turn = s1_ff.turn;
      s2_in.lat  = s1_ff.lat;
   end

   // Stage 3: mix
   always_comb begin
      logic signed [13:0] fa, fd;
      fa = s2_ff.fneg ? -$signed({2'b00, s2_ff.qa}) : $signed({2'b00, s2_ff.qa});
      fd = s2_ff.fneg ? -$signed({2'b00, s2_ff.qd}) : $signed({2'b00, s2_ff.qd});
      s3_in.wheel[0] = -fa - 14'(s2_ff.turn) + 14'(s2_ff.lat);
      s3_in.wheel[1] = 14'(s2_ff.turn) + 14'(s2_ff.lat) + 14'(s2_ff.lat);
      s3_in.wheel[2] = fd - 14'(s2_ff.turn) + 14'(s2_ff.lat);
   end

   // Stage 4: magnitudes, largest and ceiling compare
   always_comb begin
      logic [12:0] hi;
      for (int w = 0; w < 3; w++) begin
         s4_in.neg[w] = s3_ff.wheel[w][13];
         s4_in.mag[w] = s3_ff.wheel[w][13] ? 13'(-$signed(s3_ff.wheel[w]))
                                           : s3_ff.wheel[w][12:0];
      end
      hi = s4_in.mag[0];
      if (s4_in.mag[1] > hi) hi = s4_in.mag[1];
      if (s4_in.mag[2] > hi) hi = s4_in.mag[2];
      s4_in.high   = hi;
      s4_in.scaled = hi > {1'b0, ceil_eff};
   end

   // Stage 5 numerators, then the divider stages at three quotient bits each
   always_comb begin
      logic [24:0] num;
      logic [13:0] st;
      d_in[0].mag    = s4_ff.mag;
      d_in[0].neg    = s4_ff.neg;
      d_in[0].high   = s4_ff.high;
      d_in[0].scaled = s4_ff.scaled;
      for (int w = 0; w < 3; w++) begin
         num = s4_ff.scaled ? 25'(s4_ff.mag[w]) * 25'(ceil_eff) : 25'd0;
         d_in[0].rem[w] = num[24:12];
         d_in[0].low[w] = num[11:0];
         d_in[0].quo[w] = '0;
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
         d_in[s] = d_ff[s-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            for (int w = 0; w < 3; w++) begin
               st = div_step(d_in[s].rem[w], d_in[s].low[w][11], d_in[s].high);
               d_in[s].rem[w] = st[12:0];
               d_in[s].low[w] = {d_in[s].low[w][10:0], 1'b0};
               d_in[s].quo[w] = {d_in[s].quo[w][10:0], st[13]};
            end
         end
      end
   end

   // Final stage: sign, floors and packing
   always_comb begin
      logic [11:0]        m;
      logic [11:0]        fl;
      logic signed [12:0] v;
      logic               dropped;
      dropped = 1'b0;
      out_in  = '0;
      for (int w = 0; w < 3; w++) begin
         m  = d_ff[DIV_STAGES].scaled ? d_ff[DIV_STAGES].quo[w]
                                      : d_ff[DIV_STAGES].mag[w][11:0];
         fl = (w == 1) ? floor_rear_ff : floor_side_ff;
         if (m != '0 && m < fl) begin
            m       = '0;
            dropped = 1'b1;
         end
         v = d_ff[DIV_STAGES].neg[w] ? -$signed({1'b0, m}) : $signed({1'b0, m});
         out_in[w*13 +: 13] = v;
      end
      out_in[39] = d_ff[DIV_STAGES].scaled;
      out_in[40] = dropped;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ready[0]) s1_ff <= s1_in;
      if (ready[1]) s2_ff <= s2_in;
      if (ready[2]) s3_ff <= s3_in;
      if (ready[3]) s4_ff <= s4_in;
      for (int s = 0; s <= DIV_STAGES; s++) begin
         if (ready[4+s]) d_ff[s] <= d_in[s];
      end
      if (ready[NS-1]) out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = out_ff;

endmodule

>>> verif/tb_three_wheel_omni_mixer.sv
module tb_three_wheel_omni_mixer;
   import twom_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [12:0] wheel_a;
      logic signed [12:0] wheel_b;
      logic signed [12:0] wheel_d;
      logic               was_scaled;
      logic               was_dropped;
   } drive_type;

   // Scoreboard: predicts wheel drives from commands and checks responses
   class drive_scoreboard;
      int unsigned trim_a, trim_d, ceiling, floor_side, floor_rear;
      drive_type   pending[$];
      int          errors;
      int unsigned n_cmd, n_rsp, n_scaled, n_dropped;

      function void reset_regs();
         trim_a = 100; trim_d = 100; ceiling = 100; floor_side = 0; floor_rear = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [11:0] val);
         case (idx)
            CSR_TRIM_A:     trim_a = val[7:0];
            CSR_TRIM_D:     trim_d = val[7:0];
            CSR_CEILING:    ceiling = val;
            CSR_FLOOR_SIDE: floor_side = val;
            CSR_FLOOR_REAR: floor_rear = val;
            default: ;
         endcase
      endfunction

      function int mag(int v);
         return v < 0 ? -v : v;
      endfunction

      // Note an accepted command and queue the drives it must produce
      function void note_command(logic signed [10:0] fwd, logic signed [10:0] trn,
                                 logic signed [10:0] lat);
         int ta, td, cl, fa, fd, a, b, d, high;
         drive_type r;
         ta = trim_a ? trim_a : 100;
         td = trim_d ? trim_d : 100;
         cl = ceiling ? ceiling : 100;
         fa = int'(fwd) * ta / 100;
         fd = int'(fwd) * td / 100;
         a = -fa - int'(trn) + int'(lat);
         d = fd - int'(trn) + int'(lat);
         b = int'(trn) + 2 * int'(lat);
         high = mag(a);
         if (mag(b) > high) high = mag(b);
         if (mag(d) > high) high = mag(d);
         r = '0;
         if (high > cl) begin
            a = a * cl / high; b = b * cl / high; d = d * cl / high;
            r.was_scaled = 1;
         end
         if (a != 0 && mag(a) < int'(floor_side)) begin a = 0; r.was_dropped = 1; end
         if (d != 0 && mag(d) < int'(floor_side)) begin d = 0; r.was_dropped = 1; end
         if (b != 0 && mag(b) < int'(floor_rear)) begin b = 0; r.was_dropped = 1; end
         r.wheel_a = a[12:0]; r.wheel_b = b[12:0]; r.wheel_d = d[12:0];
         pending.push_back(r);
         n_cmd++;
      endfunction

      // Compare one response against the oldest expectation
      function void check_response(logic [47:0] data);
         drive_type got, exp;
         got.wheel_a = data[12:0];
         got.wheel_b = data[25:13];
         got.wheel_d = data[38:26];
         got.was_scaled = data[39];
         got.was_dropped = data[40];
         n_rsp++;
         if (pending.size() == 0) begin
            $error("response with no command outstanding: %h", data);
            errors++;
            return;
         end
         exp = pending.pop_front();
         n_scaled += exp.was_scaled;
         n_dropped += exp.was_dropped;
         if (got.wheel_a !== exp.wheel_a) begin
            $error("wheel_a expected %0d actual %0d", exp.wheel_a, got.wheel_a); errors++;
         end
         if (got.wheel_b !== exp.wheel_b) begin
            $error("wheel_b expected %0d actual %0d", exp.wheel_b, got.wheel_b); errors++;
         end
         if (got.wheel_d !== exp.wheel_d) begin
            $error("wheel_d expected %0d actual %0d", exp.wheel_d, got.wheel_d); errors++;
         end
         if (got.was_scaled !== exp.was_scaled) begin
            $error("was_scaled expected %0d actual %0d", exp.was_scaled, got.was_scaled);
            errors++;
         end
         if (got.was_dropped !== exp.was_dropped) begin
            $error("was_dropped expected %0d actual %0d", exp.was_dropped, got.was_dropped);
            errors++;
         end
      endfunction
   endclass

   localparam int LATENCY = 10;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = '0;
   logic [11:0] csr_wdata = '0;

   drive_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_off = 0;
   int  cycles = 0;

   three_wheel_omni_mixer dut (.*);

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_three_wheel_omni_mixer: done, errors");
         $finish;
      end
   end

   // Sample responses
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Receiver readiness, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one command; valid stays up into the next call when no idle cycle follows
   task automatic send_command(logic signed [10:0] fwd, logic signed [10:0] trn,
                               logic signed [10:0] lat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, lat, trn, fwd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_command(fwd, trn, lat);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [11:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   function automatic logic signed [10:0] rand_cmd();
      case ($urandom_range(5))
         0: return -11'sd1024;
         1: return 11'sd1023;
         2: return 11'(int'($urandom_range(20)) - 10);
         default: return 11'($urandom);
      endcase
   endfunction

   task automatic random_config();
      write_csr(CSR_TRIM_A, ($urandom_range(3) == 0) ? 12'd0 : 12'($urandom_range(255)));
      write_csr(CSR_TRIM_D, ($urandom_range(3) == 0) ? 12'd0 : 12'($urandom_range(255)));
      case ($urandom_range(3))
         0: write_csr(CSR_CEILING, 12'd0);
         1: write_csr(CSR_CEILING, 12'hFFF);
         default: write_csr(CSR_CEILING, 12'($urandom_range(1, 3000)));
      endcase
      write_csr(CSR_FLOOR_SIDE, ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom_range(300)));
      write_csr(CSR_FLOOR_REAR, ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom_range(300)));
   endtask

   initial begin
      int ph;
      sb.reset_regs();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes and small values at reset settings
      send_command(0, 0, 0);
      send_command(-11'sd1024, -11'sd1024, -11'sd1024);
      send_command(11'sd1023, 11'sd1023, 11'sd1023);
      send_command(-11'sd1024, 11'sd1023, -11'sd1024);
      send_command(11'sd1023, -11'sd1024, 11'sd1023);
      send_command(11'sd5, -11'sd3, 11'sd1);
      send_command(-11'sd1, 0, 0);
      drain();
      // Zero trims and ceiling mean 100; small floors drop small wheels
      write_csr(CSR_TRIM_A, 12'd0);
      write_csr(CSR_TRIM_D, 12'd0);
      write_csr(CSR_CEILING, 12'd0);
      write_csr(CSR_FLOOR_SIDE, 12'd20);
      write_csr(CSR_FLOOR_REAR, 12'd20);
      send_command(11'sd10, 11'sd3, 11'sd2);
      send_command(11'sd1023, 0, 11'sd7);
      send_command(-11'sd7, 11'sd9, -11'sd1);
      drain();
      // Trims above 200, widest ceiling, wide write keeps low bits, bad index ignored
      write_csr(CSR_TRIM_A, 12'hFFF);
      write_csr(CSR_TRIM_D, 12'd201);
      write_csr(CSR_CEILING, 12'hFFF);
      write_csr(CSR_FLOOR_SIDE, 12'hFFF);
      write_csr(CSR_FLOOR_REAR, 12'd0);
      csr_we <= 1; csr_addr <= 3'd7; csr_wdata <= 12'd1;
      @(negedge clock);
      csr_we <= 0;
      send_command(11'sd1023, -11'sd1024, 11'sd1023);
      send_command(-11'sd1024, 11'sd1023, -11'sd1024);
      send_command(11'sd100, 11'sd5, -11'sd5);
      send_command(11'sd1, 11'sd1, 11'sd1);
      drain();

      // Back-pressure: hold the receiver off while commands keep coming
      hold_off <= 80;
      for (int i = 0; i < 40; i++) send_command(rand_cmd(), rand_cmd(), rand_cmd());
      drain();

      // Random phases with varied idling
      for (ph = 0; ph < 12; ph++) begin
         random_config();
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         for (int i = 0; i < 72; i++) send_command(rand_cmd(), rand_cmd(), rand_cmd());
         drain();
      end

      $display("covered %0d commands, %0d responses; %0d scaled, %0d with a wheel dropped",
               sb.n_cmd, sb.n_rsp, sb.n_scaled, sb.n_dropped);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_three_wheel_omni_mixer: done, clean");
      end else begin
         $display("tb_three_wheel_omni_mixer: done, errors");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/twom_pkg.sv
rtl/three_wheel_omni_mixer.sv
verif/tb_three_wheel_omni_mixer.sv
